@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL in this folder.
// No dependencies; concurrent assertions collapse to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// cons holds in the same cycle as ante
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/bfd_pkg.sv @@
// Package for the box filter downsampler: field widths, register indexes,
// reset values and default size limits. No dependencies.
package bfd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_FACTOR = 16;

    localparam int COLOR_W    = 16;
    localparam int ATTR_W     = 32;
    localparam int FRAC_W     = 8;
    localparam int MEAN_W     = 24;
    localparam int FACTOR_W   = 5;
    localparam int DIM_W      = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_FACTOR = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd2;
    localparam logic [DIM_W-1:0]    RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]    RST_HEIGHT = 11'd480;

endpackage

@@ rtl/core/box_filter_downsampler_top.sv @@
// Box filter downsampler top level; uses bfd_pkg and assert_macros.svh.
// Factor 0 or 1 (copy): result registered in the cycle after the request, 1 pixel/cycle unless the output stalls.
// Factor 2+: each pixel walks 9 candidate windows in S_SCAN, plus an S_UPD step per
// window it falls in (read-modify-write of the sum memory); no new pixel is taken meanwhile.
// A finished window adds a 3-channel restoring divide of a DW (34) bit dividend.
// Reset (sync, active low) restores control registers and counters; no memory sweep.
`include "assert_macros.svh"

module box_filter_downsampler_top
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COLOR_W-1:0]    i_red_in,
    input  logic [COLOR_W-1:0]    i_green_in,
    input  logic [COLOR_W-1:0]    i_blue_in,
    input  logic [ATTR_W-1:0]     i_depth_in,
    input  logic [ATTR_W-1:0]     i_object_in,
    input  logic [ATTR_W-1:0]     i_part_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [MEAN_W-1:0]     o_red_mean,
    output logic [MEAN_W-1:0]     o_green_mean,
    output logic [MEAN_W-1:0]     o_blue_mean,
    output logic [ATTR_W-1:0]     o_depth_out,
    output logic [ATTR_W-1:0]     o_object_out,
    output logic [ATTR_W-1:0]     o_part_out,
    output logic                  o_frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int AXW  = (CW > RW) ? CW : RW;
    localparam int WDW  = $clog2(MAX_WIDTH + 1);
    localparam int HDW  = $clog2(MAX_HEIGHT + 1);
    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int PW   = $clog2(MAX_FACTOR);
    localparam int SPW  = $clog2(MAX_FACTOR + 3);
    localparam int CNTW = 2 * SPW;
    localparam int SW   = COLOR_W + CNTW;
    localparam int DW   = SW + FRAC_W;
    localparam int DCW  = $clog2(DW + 1);
    localparam int AW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH / 2) : 1;
    localparam int EW   = AXW + FW + 2;
    localparam int MEM_DEPTH = 2 ** (AW + 1);

    localparam logic [1:0] D_PREV = 2'd0;
    localparam logic [1:0] D_SAME = 2'd1;
    localparam logic [1:0] D_NEXT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    typedef struct packed {
        logic           ok;
        logic           first;
        logic           last;
        logic           anchor;
        logic           fin;
        logic [SPW-1:0] span;
        logic [AXW-1:0] idx;
    } t_axis;

    typedef struct packed {
        logic           first;
        logic           last;
        logic           anchor;
        logic           fin;
        logic [SPW-1:0] span_x;
        logic [SPW-1:0] span_y;
        logic [AW:0]    addr;
    } t_hit;

    // Evaluate one candidate window along one axis for the current pixel
    function automatic t_axis axis_eval(
        input logic [AXW-1:0] pos,
        input logic [PW-1:0]  ph,
        input logic [AXW-1:0] blk,
        input logic [1:0]     dsel,
        input logic [FW-1:0]  f,
        input logic [EW-1:0]  n
    );
        logic              wide;
        logic              on_ph0;
        logic              on_phl;
        logic              sel;
        logic [AXW-1:0]    cand;
        logic [AXW+FW-1:0] prod;
        logic [EW-1:0]     nxt1;
        logic [EW-1:0]     nxt2;
        logic [EW-1:0]     lo;
        logic [EW-1:0]     span;
        t_axis             a;
        wide   = f >= FW'(3);
        on_ph0 = ph == '0;
        on_phl = ((FW+1)'(ph) + (FW+1)'(1)) == (FW+1)'(f);
        case (dsel)
            D_PREV: begin
                cand = blk - AXW'(1);
                sel  = wide && (blk != '0) && on_ph0;
            end
            D_SAME: begin
                cand = blk;
                sel  = 1'b1;
            end
            D_NEXT: begin
                cand = blk + AXW'(1);
                sel  = wide && on_phl;
            end
            default: begin
                cand = blk;
                sel  = 1'b0;
            end
        endcase
        prod = (AXW+FW)'(cand) * (AXW+FW)'(f);
        nxt1 = EW'(prod) + EW'(f);
        nxt2 = nxt1 + EW'(f);
        lo   = EW'(prod) - ((wide && (cand != '0)) ? EW'(1) : EW'(0));
        span = EW'(pos) + EW'(1) - lo;
        a.ok     = sel && (nxt1 <= n) && (EW'(pos) + EW'(2) <= n);
        a.first  = (dsel == D_NEXT) || ((dsel == D_SAME) && on_ph0 && (!wide || blk == '0));
        a.last   = (EW'(pos) + EW'(2) == n) ||
                   (wide ? (dsel == D_PREV) : ((dsel == D_SAME) && on_phl));
        a.anchor = (dsel == D_SAME) && on_ph0;
        a.fin    = nxt2 > n;
        a.span   = span[SPW-1:0];
        a.idx    = cand;
        return a;
    endfunction

    // Configuration and position state
    t_state              r_state;
    logic [FACTOR_W-1:0] r_factor;
    logic [DIM_W-1:0]    r_src_width;
    logic [DIM_W-1:0]    r_src_height;
    logic [CW-1:0]       r_col,  n_col;
    logic [PW-1:0]       r_cph,  n_cph;
    logic [CW-1:0]       r_cblk, n_cblk;
    logic [RW-1:0]       r_row,  n_row;
    logic [PW-1:0]       r_rph,  n_rph;
    logic [RW-1:0]       r_rblk, n_rblk;
    logic [1:0]          r_dx, r_dy;
    logic                r_emitted;

    // Pixel, hit and memory read data
    logic [COLOR_W-1:0]  r_pix_col [3];
    logic [3*ATTR_W-1:0] r_pix_attr;
    t_hit                r_hit;
    logic [3*SW-1:0]     r_sum_rd;
    logic [3*ATTR_W-1:0] r_anc_rd;
    logic [3*SW-1:0]     sum_mem [MEM_DEPTH];
    logic [3*ATTR_W-1:0] anc_mem [MEM_DEPTH];

    // Divider and output register
    logic                r_div_busy;
    logic                r_div_done;
    logic [DCW-1:0]      r_div_cnt;
    logic [CNTW-1:0]     r_div_den;
    logic [CNTW-1:0]     r_rem [3];
    logic [DW-1:0]       r_dq  [3];
    logic [3*ATTR_W-1:0] r_div_attr;
    logic                r_div_end;
    logic                r_out_valid;
    logic [MEAN_W-1:0]   r_out_mean [3];
    logic [3*ATTR_W-1:0] r_out_attr;
    logic                r_out_end;

    logic [FW-1:0]       f_eff;
    logic [WDW-1:0]      w_eff;
    logic [HDW-1:0]      h_eff;
    logic                copy_mode;
    logic [COLOR_W-1:0]  in_col [3];
    logic                in_acc;
    logic                col_wrap, row_wrap, cph_wrap, rph_wrap;
    t_axis               ax, ay;
    logic                hit;
    logic                last_cand;
    logic                adv;
    logic                step;
    logic                emit_now;
    logic [3*SW-1:0]     sum_wdata;
    logic [CNTW:0]       div_tmp [3];
    logic [CNTW:0]       div_sub [3];
    logic [2:0]          div_ge;
    logic                div_to_out;

    // Clamp configuration to the supported range
    always_comb begin
        f_eff = (r_factor > MAX_FACTOR) ? FW'(MAX_FACTOR) : FW'(r_factor);
        if (r_src_width == '0) begin
            w_eff = WDW'(1);
        end else if (r_src_width > MAX_WIDTH) begin
            w_eff = WDW'(MAX_WIDTH);
        end else begin
            w_eff = WDW'(r_src_width);
        end
        if (r_src_height == '0) begin
            h_eff = HDW'(1);
        end else if (r_src_height > MAX_HEIGHT) begin
            h_eff = HDW'(MAX_HEIGHT);
        end else begin
            h_eff = HDW'(r_src_height);
        end
    end

    assign copy_mode = f_eff <= FW'(1);
    assign in_col[0] = i_red_in;
    assign in_col[1] = i_green_in;
    assign in_col[2] = i_blue_in;

    assign o_in_ready = (r_state == S_IDLE) && !r_div_busy && !r_div_done &&
                        (!copy_mode || !r_out_valid || i_out_ready);
    assign in_acc = i_in_valid && o_in_ready;

    // Advance the raster position with block index and phase inside the block
    always_comb begin
        col_wrap = (EW'(r_col) + EW'(1)) >= EW'(w_eff);
        row_wrap = (EW'(r_row) + EW'(1)) >= EW'(h_eff);
        cph_wrap = ((FW+1)'(r_cph) + (FW+1)'(1)) >= (FW+1)'(f_eff);
        rph_wrap = ((FW+1)'(r_rph) + (FW+1)'(1)) >= (FW+1)'(f_eff);
        n_col  = col_wrap ? '0 : r_col + CW'(1);
        n_cph  = (col_wrap || cph_wrap) ? '0 : r_cph + PW'(1);
        n_cblk = col_wrap ? '0 : (cph_wrap ? r_cblk + CW'(1) : r_cblk);
        n_row  = r_row;
        n_rph  = r_rph;
        n_rblk = r_rblk;
        if (col_wrap) begin
            n_row  = row_wrap ? '0 : r_row + RW'(1);
            n_rph  = (row_wrap || rph_wrap) ? '0 : r_rph + PW'(1);
            n_rblk = row_wrap ? '0 : (rph_wrap ? r_rblk + RW'(1) : r_rblk);
        end
    end

    // Candidate window test for the current scan step
    always_comb begin
        ax = axis_eval(AXW'(r_col), r_cph, AXW'(r_cblk), r_dx, f_eff, EW'(w_eff));
        ay = axis_eval(AXW'(r_row), r_rph, AXW'(r_rblk), r_dy, f_eff, EW'(h_eff));
    end

    assign hit       = (r_state == S_SCAN) && ax.ok && ay.ok;
    assign last_cand = (r_dx == D_NEXT) && (r_dy == D_NEXT);
    assign adv  = (in_acc && copy_mode) ||
                  (((r_state == S_SCAN) && !hit) || (r_state == S_UPD)) && last_cand;
    assign step = (((r_state == S_SCAN) && !hit) || (r_state == S_UPD)) && !last_cand;
    assign emit_now = (r_state == S_UPD) && r_hit.last && !r_emitted;

    // Accumulate: restart on the window's first pixel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum_wdata[ch*SW +: SW] = (r_hit.first ? SW'(0) : r_sum_rd[ch*SW +: SW]) +
                                     SW'(r_pix_col[ch]);
        end
    end

    // One restoring divide step per channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            div_tmp[ch] = {r_rem[ch], r_dq[ch][DW-1]};
            div_sub[ch] = div_tmp[ch] - (CNTW+1)'(r_div_den);
            div_ge[ch]  = div_tmp[ch] >= (CNTW+1)'(r_div_den);
        end
    end

    assign div_to_out = r_div_done && (!r_out_valid || i_out_ready);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_factor     <= RST_FACTOR;
            r_src_width  <= RST_WIDTH;
            r_src_height <= RST_HEIGHT;
            r_col        <= '0;
            r_cph        <= '0;
            r_cblk       <= '0;
            r_row        <= '0;
            r_rph        <= '0;
            r_rblk       <= '0;
            r_dx         <= D_PREV;
            r_dy         <= D_PREV;
            r_emitted    <= 1'b0;
            r_div_busy   <= 1'b0;
            r_div_done   <= 1'b0;
            r_div_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // walk the candidate windows
            case (r_state)
                S_IDLE: begin
                    if (in_acc && !copy_mode) begin
                        r_state   <= S_SCAN;
                        r_dx      <= D_PREV;
                        r_dy      <= D_PREV;
                        r_emitted <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_state <= S_UPD;
                    end else if (last_cand) begin
                        r_state <= S_IDLE;
                    end
                end
                S_UPD: begin
                    if (emit_now) begin
                        r_emitted <= 1'b1;
                    end
                    r_state <= last_cand ? S_IDLE : S_SCAN;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (step) begin
                if (r_dx == D_NEXT) begin
                    r_dx <= D_PREV;
                    r_dy <= r_dy + 2'd1;
                end else begin
                    r_dx <= r_dx + 2'd1;
                end
            end
            if (adv) begin
                r_col  <= n_col;
                r_cph  <= n_cph;
                r_cblk <= n_cblk;
                r_row  <= n_row;
                r_rph  <= n_rph;
                r_rblk <= n_rblk;
            end
            // divider sequencing
            if (emit_now) begin
                r_div_busy <= 1'b1;
                r_div_cnt  <= DCW'(DW);
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - DCW'(1);
                if (r_div_cnt == DCW'(1)) begin
                    r_div_busy <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
            if (div_to_out) begin
                r_div_done <= 1'b0;
            end
            // output register
            if (div_to_out || (in_acc && copy_mode)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // writes to the factor, width or height register restart the frame
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FACTOR: r_factor     <= i_cfg_data[FACTOR_W-1:0];
                    CFG_WIDTH:  r_src_width  <= i_cfg_data[DIM_W-1:0];
                    CFG_HEIGHT: r_src_height <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
                if (i_cfg_addr == CFG_FACTOR || i_cfg_addr == CFG_WIDTH ||
                    i_cfg_addr == CFG_HEIGHT) begin
                    r_col  <= '0;
                    r_cph  <= '0;
                    r_cblk <= '0;
                    r_row  <= '0;
                    r_rph  <= '0;
                    r_rblk <= '0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_pix_col[ch] <= in_col[ch];
            end
            r_pix_attr <= {i_part_in, i_object_in, i_depth_in};
        end
        if (hit) begin
            r_hit.first  <= ax.first && ay.first;
            r_hit.last   <= ax.last && ay.last;
            r_hit.anchor <= ax.anchor && ay.anchor;
            r_hit.fin    <= ax.fin && ay.fin;
            r_hit.span_x <= ax.span;
            r_hit.span_y <= ay.span;
            r_hit.addr   <= {ay.idx[0], ax.idx[AW-1:0]};
        end
        // load or step the divider
        if (emit_now) begin
            r_div_den  <= CNTW'(r_hit.span_x) * CNTW'(r_hit.span_y);
            r_div_attr <= r_hit.anchor ? r_pix_attr : r_anc_rd;
            r_div_end  <= r_hit.fin;
            for (int ch = 0; ch < 3; ch++) begin
                r_rem[ch] <= '0;
                r_dq[ch]  <= {sum_wdata[ch*SW +: SW], {FRAC_W{1'b0}}};
            end
        end else if (r_div_busy) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_rem[ch] <= div_ge[ch] ? div_sub[ch][CNTW-1:0] : div_tmp[ch][CNTW-1:0];
                r_dq[ch]  <= {r_dq[ch][DW-2:0], div_ge[ch]};
            end
        end
        // hold the result until taken
        if (in_acc && copy_mode) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_mean[ch] <= MEAN_W'({in_col[ch], {FRAC_W{1'b0}}});
            end
            r_out_attr <= {i_part_in, i_object_in, i_depth_in};
            r_out_end  <= col_wrap && row_wrap;
        end else if (div_to_out) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_out_mean[ch] <= r_dq[ch][MEAN_W-1:0];
            end
            r_out_attr <= r_div_attr;
            r_out_end  <= r_div_end;
        end
    end

    // Window sum and anchor memories, with registered reads
    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_sum_rd <= sum_mem[{ay.idx[0], ax.idx[AW-1:0]}];
            r_anc_rd <= anc_mem[{ay.idx[0], ax.idx[AW-1:0]}];
        end
        if (r_state == S_UPD) begin
            sum_mem[r_hit.addr] <= sum_wdata;
        end
        if ((r_state == S_UPD) && r_hit.anchor) begin
            anc_mem[r_hit.addr] <= r_pix_attr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_red_mean   = r_out_mean[0];
    assign o_green_mean = r_out_mean[1];
    assign o_blue_mean  = r_out_mean[2];
    assign o_depth_out  = r_out_attr[0 +: ATTR_W];
    assign o_object_out = r_out_attr[ATTR_W +: ATTR_W];
    assign o_part_out   = r_out_attr[2*ATTR_W +: ATTR_W];
    assign o_frame_end  = r_out_end;

    `ASSERT_IMPL(a_launch_idle, i_clk, i_rst_n, emit_now, !r_div_busy && !r_div_done)
    `ASSERT_ALWAYS(a_col_range, i_clk, i_rst_n, EW'(r_col) < EW'(w_eff))
    `ASSERT_ALWAYS(a_row_range, i_clk, i_rst_n, EW'(r_row) < EW'(h_eff))
    `ASSERT_IMPL(a_phase_range, i_clk, i_rst_n, f_eff >= FW'(2), (FW+1)'(r_cph) < (FW+1)'(f_eff))
    `ASSERT_NEXT(a_scan_start, i_clk, i_rst_n, in_acc && !copy_mode, r_state == S_SCAN)

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for box_filter_downsampler_top: a pixel scoreboard
// predicts window means and anchor attributes, random traffic drives both sides.
// Depends on bfd_pkg and the RTL under rtl/core.
module tb_top;
    import bfd_pkg::*;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int MAXF       = 16;
    localparam int DRAIN_WAIT = 80;
    localparam int CYCLE_CAP  = 600000;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [ATTR_W-1:0]  depth;
        logic [ATTR_W-1:0]  object;
        logic [ATTR_W-1:0]  part;
    } t_pixel;

    typedef struct packed {
        logic [MEAN_W-1:0] red;
        logic [MEAN_W-1:0] green;
        logic [MEAN_W-1:0] blue;
        logic [ATTR_W-1:0] depth;
        logic [ATTR_W-1:0] object;
        logic [ATTR_W-1:0] part;
        logic              frame_end;
    } t_mean;

    // Window-mean predictor and the queue of pending output pixels
    class mean_scoreboard;
        int unsigned       fac, wid, hei, col_pos, row_pos;
        longint unsigned   sums [2][MAXW][3];
        bit [ATTR_W-1:0]   anchor [2][MAXW][3];
        t_mean             pending_means [$];
        int                errors;

        function new();
            fac = RST_FACTOR;
            wid = RST_WIDTH;
            hei = RST_HEIGHT;
            col_pos = 0;
            row_pos = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("tb_top: mismatch: %s", msg);
            errors++;
        endtask

        function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
            if (v < 1) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        // Window [lo, hi) along one axis for output index i
        function void span(int unsigned i, int unsigned f, int unsigned n,
                           output int unsigned lo, output int unsigned hi);
            int unsigned base;
            base = i * f;
            hi = base + f + ((f >= 3) ? 1 : 0);
            lo = (f >= 3 && base > 0) ? base - 1 : base;
            if (hi > n - 1) hi = n - 1;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FACTOR: fac = data & 31;
                CFG_WIDTH:  wid = data;
                CFG_HEIGHT: hei = data;
                default: return;
            endcase
            col_pos = 0;
            row_pos = 0;
        endfunction

        // Advance the raster position and queue the output pixel this request completes
        function void note_pixel(t_pixel p);
            int unsigned     f, w, h, c, r, ow, oh, yc, xc, y, x, ylo, yhi, xlo, xhi, b, k;
            bit              done;
            longint unsigned cnt;
            longint unsigned colv [3];
            bit [ATTR_W-1:0] attr [3];
            t_mean           e;
            f = (fac > MAXF) ? MAXF : fac;
            w = clamp_dim(wid, MAXW);
            h = clamp_dim(hei, MAXH);
            c = col_pos;
            r = row_pos;
            colv[0] = p.red;   colv[1] = p.green;  colv[2] = p.blue;
            attr[0] = p.depth; attr[1] = p.object; attr[2] = p.part;
            done = 0;
            if (c >= w) c = 0;
            if (r >= h) r = 0;
            if (c + 1 >= w) begin
                col_pos = 0;
                row_pos = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
                row_pos = r;
            end
            if (f <= 1) begin
                e.red = {p.red, 8'h00};
                e.green = {p.green, 8'h00};
                e.blue = {p.blue, 8'h00};
                e.depth = p.depth;
                e.object = p.object;
                e.part = p.part;
                e.frame_end = (c == w - 1 && r == h - 1);
                pending_means.push_back(e);
                return;
            end
            ow = w / f;
            oh = h / f;
            yc = r / f;
            xc = c / f;
            for (y = (yc > 0 ? yc - 1 : 0); y <= yc + 1 && y < oh; y++) begin
                span(y, f, h, ylo, yhi);
                if (r < ylo || r >= yhi) continue;
                b = y & 1;
                for (x = (xc > 0 ? xc - 1 : 0); x <= xc + 1 && x < ow; x++) begin
                    span(x, f, w, xlo, xhi);
                    if (c < xlo || c >= xhi) continue;
                    // clear on the window's first pixel, then accumulate
                    if (r == ylo && c == xlo)
                        for (k = 0; k < 3; k++) sums[b][x][k] = 0;
                    for (k = 0; k < 3; k++) sums[b][x][k] += colv[k];
                    if (c == x * f && r == y * f)
                        for (k = 0; k < 3; k++) anchor[b][x][k] = attr[k];
                    if (r == yhi - 1 && c == xhi - 1 && !done) begin
                        cnt = longint'(xhi - xlo) * longint'(yhi - ylo);
                        e.red = MEAN_W'((sums[b][x][0] << 8) / cnt);
                        e.green = MEAN_W'((sums[b][x][1] << 8) / cnt);
                        e.blue = MEAN_W'((sums[b][x][2] << 8) / cnt);
                        e.depth = anchor[b][x][0];
                        e.object = anchor[b][x][1];
                        e.part = anchor[b][x][2];
                        e.frame_end = (x == ow - 1 && y == oh - 1);
                        pending_means.push_back(e);
                        done = 1;
                    end
                end
            end
        endfunction

        // Compare one output pixel with the oldest pending one
        task check_result(t_mean got);
            t_mean e;
            if (pending_means.size() == 0) begin
                report($sformatf("unexpected output pixel %p", got));
                return;
            end
            e = pending_means.pop_front();
            if (got.red !== e.red)
                report($sformatf("red_mean %h, want %h", got.red, e.red));
            if (got.green !== e.green)
                report($sformatf("green_mean %h, want %h", got.green, e.green));
            if (got.blue !== e.blue)
                report($sformatf("blue_mean %h, want %h", got.blue, e.blue));
            if (got.depth !== e.depth)
                report($sformatf("depth_out %h, want %h", got.depth, e.depth));
            if (got.object !== e.object)
                report($sformatf("object_out %h, want %h", got.object, e.object));
            if (got.part !== e.part)
                report($sformatf("part_out %h, want %h", got.part, e.part));
            if (got.frame_end !== e.frame_end)
                report($sformatf("frame_end %b, want %b", got.frame_end, e.frame_end));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [COLOR_W-1:0]    i_red_in, i_green_in, i_blue_in;
    logic [ATTR_W-1:0]     i_depth_in, i_object_in, i_part_in;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [MEAN_W-1:0]     o_red_mean, o_green_mean, o_blue_mean;
    logic [ATTR_W-1:0]     o_depth_out, o_object_out, o_part_out;
    logic                  o_frame_end;

    mean_scoreboard sb = new();
    int             cycle_count = 0;
    int             hold_asked = 0;
    int             hold_served = 0;
    int             hold_left = 0;
    bit             quiet_sender = 0;

    box_filter_downsampler_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_red_in(i_red_in), .i_green_in(i_green_in), .i_blue_in(i_blue_in),
        .i_depth_in(i_depth_in), .i_object_in(i_object_in), .i_part_in(i_part_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_red_mean(o_red_mean), .o_green_mean(o_green_mean), .o_blue_mean(o_blue_mean),
        .o_depth_out(o_depth_out), .o_object_out(o_object_out), .o_part_out(o_part_out),
        .o_frame_end(o_frame_end)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Check accepted output pixels and drive ready with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_red_mean, o_green_mean, o_blue_mean, o_depth_out,
                              o_object_out, o_part_out, o_frame_end});
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if ((cycle_count / 400) % 3 == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            if ($urandom_range(0, 299) == 0) hold_left = $urandom_range(15, 60);
            i_out_ready <= ($urandom_range(0, 99) < 75);
        end
    end

    // Write one register, then leave the port idle before returning
    task write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one pixel, hold it until accepted, then maybe idle
    task send_pixel(t_pixel p);
        int gap;
        int roll;
        i_in_valid <= 1'b1;
        {i_red_in, i_green_in, i_blue_in, i_depth_in, i_object_in, i_part_in} <= p;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(p);
        roll = $urandom_range(0, 99);
        gap = 0;
        if (!quiet_sender) begin
            if (roll < 25) gap = $urandom_range(1, 3);
            else if (roll < 29) gap = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function t_pixel edge_pixel(int i);
        t_pixel p;
        case (i % 4)
            0: p = '0;
            1: p = '1;
            2: p = {16'h5555, 16'hAAAA, 16'h5555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA};
            default: p = {16'hAAAA, 16'h5555, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555};
        endcase
        return p;
    endfunction

    function t_pixel random_pixel();
        t_pixel p;
        p.red = $urandom;
        p.green = $urandom;
        p.blue = $urandom;
        p.depth = $urandom;
        p.object = $urandom;
        p.part = $urandom;
        return p;
    endfunction

    // Drop valid, let every pending output pixel drain, then the pipeline settle
    task drain();
        i_in_valid <= 1'b0;
        while (sb.pending_means.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Phase table: factor, width, height, pixels
    int ph_factor [9] = '{1, 0,    2, 3,  2, 17, 4, 2, 5};
    int ph_width  [9] = '{5, 2047, 4, 7,  5, 17, 9, 1, 12};
    int ph_height [9] = '{2, 0,    4, 7,  3, 16, 8, 1, 11};
    int ph_count  [9] = '{20, 12, 32, 49, 30, 272, 72, 10, 132};

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_out_ready = 0;
        {i_red_in, i_green_in, i_blue_in, i_depth_in, i_object_in, i_part_in} = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unused register index must leave the frame alone
        write_reg(CFG_SPARE, 11'h7FF);
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(CFG_FACTOR, CFG_DATA_W'(ph_factor[ph]));
            write_reg(CFG_WIDTH, CFG_DATA_W'(ph_width[ph]));
            write_reg(CFG_HEIGHT, CFG_DATA_W'(ph_height[ph]));
            quiet_sender = (ph % 3 == 2);
            // long receiver hold-off while the sender keeps offering
            if (ph == 3) hold_asked++;
            for (int i = 0; i < ph_count[ph]; i++)
                send_pixel(ph == 0 ? edge_pixel(i) : random_pixel());
            drain();
        end
        // high factor bits are dropped: 0x7E2 acts as factor 2
        write_reg(CFG_FACTOR, 11'h7E2);
        write_reg(CFG_WIDTH, CFG_DATA_W'(6));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(4));
        for (int i = 0; i < 24; i++) send_pixel(random_pixel());
        drain();

        if (sb.pending_means.size() != 0)
            sb.report($sformatf("%0d output pixels never arrived", sb.pending_means.size()));
        if (sb.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
